// ===== hdl/cpg_pkg.sv =====
// Shared types and constants for the circle outline pixel generator.
// No dependencies; imported by cpg_pix_unit and the top level.
`timescale 1ns / 1ps

package cpg_pkg;

    localparam int PIX_W     = 17;   // pixel index field width
    localparam int COL_W     = 8;    // centre column width
    localparam int ROW_W     = 9;    // centre row width
    localparam int RAD_W     = 6;    // radius width
    localparam int CHAN_W    = 8;    // one colour channel
    localparam int COLOUR_W  = 16;   // ARGB4444 word
    localparam int D_W       = 12;   // decision variable, signed
    localparam int MAX_STEPS = 46;   // bound on results per circle
    localparam int STEP_W    = 6;    // holds 0..MAX_STEPS

    typedef logic [PIX_W-1:0]         t_pix;
    typedef logic [2:0]               t_oct;   // which of the eight mirrored points
    typedef logic [RAD_W-1:0]         t_off;
    typedef logic signed [D_W-1:0]    t_dec;

    localparam t_dec D_START = t_dec'(3);
    localparam t_dec D_INC_A = t_dec'(6);
    localparam t_dec D_INC_B = t_dec'(10);

endpackage

// ===== hdl/cpg_pix_unit.sv =====
// Shared pixel address unit: mirrors one octant point about the centre
// and forms row*SCREEN_WIDTH+col modulo 2^17. Depends on cpg_pkg.
`timescale 1ns / 1ps

module cpg_pix_unit import cpg_pkg::*; #(
    parameter int SCREEN_WIDTH = 240
) (
    input  logic [COL_W-1:0] i_cx,
    input  logic [ROW_W-1:0] i_cy,
    input  t_off             i_x,
    input  t_off             i_y,
    input  t_oct             i_oct,
    output t_pix             o_index
);

    t_off u;
    t_off v;
    t_pix col;
    t_pix row;
    t_pix row_base;

    // Upper four points use (x, y), lower four swap the offsets.
    // Bit 0 negates the column offset, bit 1 the row offset.
    always_comb begin
        u = i_oct[2] ? i_y : i_x;
        v = i_oct[2] ? i_x : i_y;
        col = i_oct[0] ? (PIX_W'(i_cx) - PIX_W'(u)) : (PIX_W'(i_cx) + PIX_W'(u));
        row = i_oct[1] ? (PIX_W'(i_cy) - PIX_W'(v)) : (PIX_W'(i_cy) + PIX_W'(v));
        row_base = PIX_W'(row * PIX_W'(SCREEN_WIDTH));
        o_index = row_base + col;
    end

endmodule

// ===== hdl/circle_outline_pixel_generator_top.sv =====
// Top level of the circle outline pixel generator: command check, step
// sequencer, midpoint recurrence and output register. Uses cpg_pkg, cpg_pix_unit.
// Flow: the command is registered, S_CALC sends the eight mirrored points
// through the one shared pixel address unit in turn, and S_LOAD hands the step
// to the output register once it is free; a rejected circle gives its single
// result from S_REJ. A new command is taken only once the last result is loaded.
// Reset: synchronous active low; clears the sequencer, output valid and layer.
`timescale 1ns / 1ps

module circle_outline_pixel_generator_top import cpg_pkg::*; #(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 320,
    parameter int MAX_RADIUS    = 63
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [COL_W-1:0]    i_centre_col,
    input  logic [ROW_W-1:0]    i_centre_row,
    input  logic [RAD_W-1:0]    i_radius,
    input  logic [CHAN_W-1:0]   i_alpha_in,
    input  logic [CHAN_W-1:0]   i_red_in,
    input  logic [CHAN_W-1:0]   i_green_in,
    input  logic [CHAN_W-1:0]   i_blue_in,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [PIX_W-1:0]    o_pixel_a,
    output logic [PIX_W-1:0]    o_pixel_b,
    output logic [PIX_W-1:0]    o_pixel_c,
    output logic [PIX_W-1:0]    o_pixel_d,
    output logic [PIX_W-1:0]    o_pixel_e,
    output logic [PIX_W-1:0]    o_pixel_f,
    output logic [PIX_W-1:0]    o_pixel_g,
    output logic [PIX_W-1:0]    o_pixel_h,
    output logic [COLOUR_W-1:0] o_packed_colour,
    output logic                o_target_layer,
    output logic                o_status,
    output logic                o_last_step
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_REJ  = 2'd3;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_REJ = 1'b1;

    logic [1:0]          r_state, n_state;
    t_oct                r_oct, n_oct;
    logic                r_layer;
    logic [COL_W-1:0]    r_cx;
    logic [ROW_W-1:0]    r_cy;
    logic [COLOUR_W-1:0] r_colour;
    t_off                r_x, n_x;
    t_off                r_y, n_y;
    t_dec                r_d, n_d;
    logic [STEP_W-1:0]   r_n, n_n;
    t_pix                r_pix [8];
    logic                r_out_valid;
    t_pix                r_out_pix [8];
    logic [COLOUR_W-1:0] r_out_colour;
    logic                r_out_layer;
    logic                r_out_status;
    logic                r_out_last;

    logic                in_take;
    logic                out_free;
    logic                cmd_ok;
    logic                d_neg;
    logic                step_last;
    logic                do_load;
    t_pix                unit_index;

    assign o_ready  = (r_state == S_IDLE);
    assign in_take  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    assign cmd_ok = (32'(i_radius) <= MAX_RADIUS) &&
                    (i_centre_col >= COL_W'(i_radius)) &&
                    (i_centre_row >= ROW_W'(i_radius)) &&
                    ((32'(i_centre_col) + 32'(i_radius)) < SCREEN_WIDTH) &&
                    ((32'(i_centre_row) + 32'(i_radius)) < SCREEN_HEIGHT);

    cpg_pix_unit #(
        .SCREEN_WIDTH(SCREEN_WIDTH)
    ) u_pix_unit (
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_oct   (r_oct),
        .o_index (unit_index)
    );

    // Recurrence update, applied when a step is handed to the output register.
    always_comb begin
        d_neg = r_d[D_W-1];
        n_x   = r_x + t_off'(1);
        n_n   = r_n + STEP_W'(1);
        if (d_neg) begin
            n_d = r_d + t_dec'({r_x, 2'b00}) + D_INC_A;
            n_y = r_y;
        end else begin
            n_d = r_d + ((t_dec'(r_x) - t_dec'(r_y)) <<< 2) + D_INC_B;
            n_y = r_y - t_off'(1);
        end
        // y stepping below zero ends the circle as well as x passing y
        step_last = (!d_neg && (r_y == '0)) || (n_x > n_y) ||
                    (32'(n_n) >= MAX_STEPS);
    end

    always_comb begin
        n_state = r_state;
        n_oct   = r_oct;
        do_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = cmd_ok ? S_CALC : S_REJ;
                end
            end
            S_CALC: begin
                n_oct = r_oct + t_oct'(1);
                if (r_oct == '1) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    do_load = 1'b1;
                    n_state = step_last ? S_IDLE : S_CALC;
                end
            end
            S_REJ: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oct       <= '0;
            r_layer     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oct   <= n_oct;
            if (i_cfg_we) begin
                r_layer <= i_cfg_data;
            end
            if (do_load || ((r_state == S_REJ) && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command, recurrence and mirrored pixel registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cx     <= i_centre_col;
            r_cy     <= i_centre_row;
            r_colour <= {i_alpha_in[CHAN_W-1 -: 4], i_red_in[CHAN_W-1 -: 4],
                         i_green_in[CHAN_W-1 -: 4], i_blue_in[CHAN_W-1 -: 4]};
            r_x      <= '0;
            r_y      <= i_radius;
            r_d      <= D_START - (t_dec'(i_radius) <<< 1);
            r_n      <= '0;
        end else if (do_load) begin
            r_x <= n_x;
            r_y <= n_y;
            r_d <= n_d;
            r_n <= n_n;
        end
        if (r_state == S_CALC) begin
            r_pix[r_oct] <= unit_index;
        end
    end

    // Output register: hold a result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_out_pix    <= r_pix;
            r_out_colour <= r_colour;
            r_out_layer  <= r_layer;
            r_out_status <= STATUS_OK;
            r_out_last   <= step_last;
        end else if ((r_state == S_REJ) && out_free) begin
            for (int i = 0; i < 8; i++) begin
                r_out_pix[i] <= '0;
            end
            r_out_colour <= r_colour;
            r_out_layer  <= r_layer;
            r_out_status <= STATUS_REJ;
            r_out_last   <= 1'b1;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pixel_a       = r_out_pix[0];
    assign o_pixel_b       = r_out_pix[1];
    assign o_pixel_c       = r_out_pix[2];
    assign o_pixel_d       = r_out_pix[3];
    assign o_pixel_e       = r_out_pix[4];
    assign o_pixel_f       = r_out_pix[5];
    assign o_pixel_g       = r_out_pix[6];
    assign o_pixel_h       = r_out_pix[7];
    assign o_packed_colour = r_out_colour;
    assign o_target_layer  = r_out_layer;
    assign o_status        = r_out_status;
    assign o_last_step     = r_out_last;

`ifndef NO_ASSERTIONS
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> !o_ready)
        else $error("ready stayed high after a command transaction");

    a_oct_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CALC) |-> (r_oct == '0))
        else $error("octant counter not parked outside pixel calculation");

    a_calc_in_arc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> (r_x <= r_y))
        else $error("step calculated past the end of the octant");

    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_last_step && (o_pixel_a == '0) && (o_pixel_h == '0)))
        else $error("rejected circle result malformed");
`endif

endmodule

// ===== bench/circle_outline_pixel_generator_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for circle_outline_pixel_generator_top: sends circle commands with random handshake
// gaps, predicts every midpoint step and checks each result field by field.
// Depends on cpg_pkg and the generator RTL only.

module circle_outline_pixel_generator_top_tb import cpg_pkg::*;;

    localparam int   SCR_W         = 240;
    localparam int   SCR_H         = 320;
    localparam int   MAX_R         = 63;
    localparam int   SETTLE_CYCLES = 24;
    localparam int   HOLD_CYCLES   = 600;
    localparam int   CYCLE_LIMIT   = 3_000_000;
    localparam logic STATUS_DRAWN    = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;
    localparam logic LAYER_BG      = 1'b0;
    localparam logic LAYER_FG      = 1'b1;

    typedef enum int {OFF_LEFT, OFF_RIGHT, OFF_TOP, OFF_BOTTOM, OFF_ANY} t_off_side;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [RAD_W-1:0]  rad;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_circle_cmd;

    typedef struct packed {
        logic [7:0][PIX_W-1:0] pix;
        logic [COLOUR_W-1:0]   colour;
        logic                  layer;
        logic                  status;
        logic                  last;
    } t_step;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_data;
    logic                i_valid;
    logic                o_ready;
    logic [COL_W-1:0]    i_centre_col;
    logic [ROW_W-1:0]    i_centre_row;
    logic [RAD_W-1:0]    i_radius;
    logic [CHAN_W-1:0]   i_alpha_in;
    logic [CHAN_W-1:0]   i_red_in;
    logic [CHAN_W-1:0]   i_green_in;
    logic [CHAN_W-1:0]   i_blue_in;
    logic                o_valid;
    logic                i_ready;
    logic [PIX_W-1:0]    o_pixel_a;
    logic [PIX_W-1:0]    o_pixel_b;
    logic [PIX_W-1:0]    o_pixel_c;
    logic [PIX_W-1:0]    o_pixel_d;
    logic [PIX_W-1:0]    o_pixel_e;
    logic [PIX_W-1:0]    o_pixel_f;
    logic [PIX_W-1:0]    o_pixel_g;
    logic [PIX_W-1:0]    o_pixel_h;
    logic [COLOUR_W-1:0] o_packed_colour;
    logic                o_target_layer;
    logic                o_status;
    logic                o_last_step;

    t_step step_q [$];
    logic  layer_now  = LAYER_BG;
    bit    steady     = 1'b0;
    bit    hold_req   = 1'b0;
    int    errors     = 0;
    int    n_circles  = 0;
    int    n_rejected = 0;
    int    n_results  = 0;
    string pix_names  = "abcdefgh";

    circle_outline_pixel_generator_top #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H),
        .MAX_RADIUS    (MAX_R)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_centre_col    (i_centre_col),
        .i_centre_row    (i_centre_row),
        .i_radius        (i_radius),
        .i_alpha_in      (i_alpha_in),
        .i_red_in        (i_red_in),
        .i_green_in      (i_green_in),
        .i_blue_in       (i_blue_in),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_a       (o_pixel_a),
        .o_pixel_b       (o_pixel_b),
        .o_pixel_c       (o_pixel_c),
        .o_pixel_d       (o_pixel_d),
        .o_pixel_e       (o_pixel_e),
        .o_pixel_f       (o_pixel_f),
        .o_pixel_g       (o_pixel_g),
        .o_pixel_h       (o_pixel_h),
        .o_packed_colour (o_packed_colour),
        .o_target_layer  (o_target_layer),
        .o_status        (o_status),
        .o_last_step     (o_last_step)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_pix pix_at(int col, int row);
        return t_pix'(row * SCR_W + col);
    endfunction

    // Expand one command into every step result it should produce.
    function automatic void predict_circle(t_circle_cmd c);
        int    cx, cy, rad, x, y, d, n;
        t_step s;
        cx = c.col;
        cy = c.row;
        rad = c.rad;
        s = '0;
        s.colour = {c.alpha[7:4], c.red[7:4], c.green[7:4], c.blue[7:4]};
        s.layer = layer_now;
        n_circles++;
        if (rad > MAX_R || cx < rad || cy < rad || cx + rad >= SCR_W || cy + rad >= SCR_H) begin
            s.status = STATUS_REJECTED;
            s.last = 1'b1;
            step_q.push_back(s);
            n_rejected++;
            return;
        end
        s.status = STATUS_DRAWN;
        x = 0;
        y = rad;
        d = 3 - 2 * rad;
        n = 0;
        while (x <= y && n < MAX_STEPS) begin
            s.pix[0] = pix_at(cx + x, cy + y);
            s.pix[1] = pix_at(cx - x, cy + y);
            s.pix[2] = pix_at(cx + x, cy - y);
            s.pix[3] = pix_at(cx - x, cy - y);
            s.pix[4] = pix_at(cx + y, cy + x);
            s.pix[5] = pix_at(cx - y, cy + x);
            s.pix[6] = pix_at(cx + y, cy - x);
            s.pix[7] = pix_at(cx - y, cy - x);
            if (d < 0) begin
                d += 4 * x + 6;
            end else begin
                d += 4 * (x - y) + 10;
                y--;
            end
            x++;
            n++;
            s.last = (x > y) || (n == MAX_STEPS);
            step_q.push_back(s);
        end
    endfunction

    // Mostly back-to-back, sometimes a few cycles, now and then a long gap.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic t_circle_cmd circle(int col, int row, int rad, logic [31:0] argb);
        t_circle_cmd c;
        c.col = COL_W'(col);
        c.row = ROW_W'(row);
        c.rad = RAD_W'(rad);
        {c.alpha, c.red, c.green, c.blue} = argb;
        return c;
    endfunction

    // Three in four circles fit the screen; the rest hang off one edge or land anywhere.
    function automatic t_circle_cmd random_circle();
        int        roll, rad, col, row;
        t_off_side side;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            rad = $urandom_range(0, 15);
        else if (roll < 90)
            rad = $urandom_range(16, 40);
        else
            rad = $urandom_range(41, MAX_R);
        if ($urandom_range(0, 99) < 75) begin
            col = $urandom_range(rad, SCR_W - 1 - rad);
            row = $urandom_range(rad, SCR_H - 1 - rad);
        end else begin
            rad = $urandom_range(1, MAX_R);
            col = $urandom_range(0, SCR_W - 1);
            row = $urandom_range(0, SCR_H - 1);
            side = t_off_side'($urandom_range(OFF_LEFT, OFF_ANY));
            case (side)
                OFF_LEFT:   col = $urandom_range(0, rad - 1);
                OFF_RIGHT:  col = $urandom_range(SCR_W - rad, SCR_W - 1);
                OFF_TOP:    row = $urandom_range(0, rad - 1);
                OFF_BOTTOM: row = $urandom_range(SCR_H - rad, SCR_H - 1);
                default:    ;
            endcase
        end
        return circle(col, row, rad, $urandom());
    endfunction

    task automatic send_circle(input t_circle_cmd c);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_centre_col <= c.col;
        i_centre_row <= c.row;
        i_radius     <= c.rad;
        i_alpha_in   <= c.alpha;
        i_red_in     <= c.red;
        i_green_in   <= c.green;
        i_blue_in    <= c.blue;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and wait until every expected step has come back and the block has settled.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (step_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_layer(input logic value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        layer_now = value;
    endtask

    task automatic test_corner_circles();
        send_circle(circle(0, 0, 0, $urandom()));
        send_circle(circle(SCR_W - 1, SCR_H - 1, 0, $urandom()));
        send_circle(circle(120, 160, 1, $urandom()));
        send_circle(circle(MAX_R, MAX_R, MAX_R, $urandom()));
        send_circle(circle(SCR_W - 1 - MAX_R, SCR_H - 1 - MAX_R, MAX_R, $urandom()));
        send_circle(circle(MAX_R - 1, 100, MAX_R, $urandom()));
        send_circle(circle(100, MAX_R - 1, MAX_R, $urandom()));
        send_circle(circle(SCR_W - MAX_R, 200, MAX_R, $urandom()));
        send_circle(circle(100, SCR_H - MAX_R, MAX_R, $urandom()));
        send_circle(circle(0, 160, 1, $urandom()));
        send_circle(circle(SCR_W - 1, 160, 1, $urandom()));
        send_circle(circle(120, 0, 1, $urandom()));
        send_circle(circle(120, SCR_H - 1, 1, $urandom()));
        send_circle(circle(128, 256, 2, $urandom()));
        send_circle(circle(120, 160, 32, $urandom()));
    endtask

    task automatic test_colour_packing();
        send_circle(circle(10, 10, 0, 32'h0000_0000));
        send_circle(circle(10, 10, 1, 32'hFFFF_FFFF));
        send_circle(circle(10, 10, 0, 32'h0F0F_0F0F));
        send_circle(circle(10, 10, 0, 32'hF0F0_F0F0));
        send_circle(circle(10, 10, 1, 32'h8040_2010));
        send_circle(circle(10, 10, 0, 32'h7F7F_7F7F));
        // colour must still be packed on a rejected circle
        send_circle(circle(0, 0, 5, 32'hFFFF_FFFF));
    endtask

    task automatic test_layer_select();
        write_layer(LAYER_FG);
        send_circle(circle(50, 50, 4, $urandom()));
        send_circle(circle(0, 50, 4, $urandom()));
        send_circle(circle(200, 300, 19, $urandom()));
        write_layer(LAYER_BG);
        send_circle(circle(50, 50, 3, $urandom()));
    endtask

    task automatic test_random_circles();
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 0)
                write_layer(LAYER_FG);
            else if (phase == 1)
                write_layer(LAYER_BG);
            else
                write_layer(logic'($urandom_range(0, 1)));
            // one phase runs with no idling on either side
            steady = (phase == 2);
            for (int k = 0; k < 60; k++)
                send_circle(random_circle());
        end
        steady = 1'b0;
    endtask

    task automatic test_input_stall();
        drain();
        hold_req = 1'b1;
        for (int k = 0; k < 8; k++)
            send_circle(random_circle());
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int stall;
        int hold_left;
        stall = 0;
        hold_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (steady) begin
                i_ready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_circle_cmd cmd;
        t_step       got;
        t_step       want;
        if (i_rst_n && i_valid && o_ready) begin
            cmd = {i_centre_col, i_centre_row, i_radius,
                   i_alpha_in, i_red_in, i_green_in, i_blue_in};
            predict_circle(cmd);
        end
        if (i_rst_n && o_valid && i_ready) begin
            got.pix = {o_pixel_h, o_pixel_g, o_pixel_f, o_pixel_e,
                       o_pixel_d, o_pixel_c, o_pixel_b, o_pixel_a};
            got.colour = o_packed_colour;
            got.layer  = o_target_layer;
            got.status = o_status;
            got.last   = o_last_step;
            n_results++;
            if (step_q.size() == 0) begin
                $display("%0t: result with nothing expected: pixel_a=%0d status=%0b last=%0b",
                         $time, o_pixel_a, o_status, o_last_step);
                errors++;
            end else begin
                want = step_q.pop_front();
                for (int k = 0; k < 8; k++) begin
                    if (got.pix[k] !== want.pix[k]) begin
                        $display("%0t: pixel_%c expected %0d actual %0d",
                                 $time, pix_names[k], want.pix[k], got.pix[k]);
                        errors++;
                    end
                end
                if (got.colour !== want.colour) begin
                    $display("%0t: packed_colour expected %h actual %h",
                             $time, want.colour, got.colour);
                    errors++;
                end
                if (got.layer !== want.layer) begin
                    $display("%0t: target_layer expected %0b actual %0b",
                             $time, want.layer, got.layer);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0b actual %0b",
                             $time, want.status, got.status);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last_step expected %0b actual %0b",
                             $time, want.last, got.last);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles, %0d steps outstanding",
                 $time, cycles, step_q.size());
        $display("** circle_outline_pixel_generator_top: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_data   <= 1'b0;
        i_valid      <= 1'b0;
        i_centre_col <= '0;
        i_centre_row <= '0;
        i_radius     <= '0;
        i_alpha_in   <= '0;
        i_red_in     <= '0;
        i_green_in   <= '0;
        i_blue_in    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_layer(LAYER_BG);

        test_corner_circles();
        test_colour_packing();
        test_layer_select();
        test_random_circles();
        test_input_stall();

        drain();
        $display("Covered %0d circle commands (%0d rejected off screen) on both layers,",
                 n_circles, n_rejected);
        $display("%0d step results checked, %0d mismatches, one long output hold-off.",
                 n_results, errors);
        if (errors == 0 && step_q.size() == 0)
            $display("** circle_outline_pixel_generator_top: PASSED **");
        else
            $display("** circle_outline_pixel_generator_top: FAILED **");
        $finish;
    end

endmodule

// ===== circle_outline_pixel_generator_top.f =====
hdl/cpg_pkg.sv
hdl/cpg_pix_unit.sv
hdl/circle_outline_pixel_generator_top.sv
bench/circle_outline_pixel_generator_top_tb.sv
